// ===== hw/rtl/tvm_pkg.sv =====
// ----------------------------------------------------------------------------
// tvm_pkg: shared types and constants of the tiny register VM core
// Opcode codes, register file geometry and fixed machine constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvm_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int WORD_W    = 16;

  typedef logic [REG_AW-1:0] reg_idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        opcode_t;

  // special register places
  localparam reg_idx_t IP_INDEX = reg_idx_t'(15);
  localparam reg_idx_t SS_INDEX = reg_idx_t'(12);
  localparam reg_idx_t SP_INDEX = reg_idx_t'(13);
  localparam reg_idx_t SU_INDEX = reg_idx_t'(14);
  localparam reg_idx_t OUT_REG  = reg_idx_t'(5);

  // stack layout used by restart
  localparam int    STACK_WORDS = 256;
  localparam word_t STACK_GAP   = word_t'(32);

  localparam int PROG_LEN_W = 13;

  // opcodes
  localparam opcode_t OP_HALT = 4'd0;
  localparam opcode_t OP_LDI  = 4'd1;
  localparam opcode_t OP_MOV  = 4'd2;
  localparam opcode_t OP_ADD  = 4'd3;
  localparam opcode_t OP_SUB  = 4'd4;
  localparam opcode_t OP_MUL  = 4'd5;
  localparam opcode_t OP_DIV  = 4'd6;
  localparam opcode_t OP_JMP  = 4'd7;
  localparam opcode_t OP_JNZ  = 4'd8;

endpackage

// ===== hw/rtl/tvm_ram.sv =====
// ----------------------------------------------------------------------------
// tvm_ram: generic RAM, one write port, two registered read ports
// Width and depth set by parameters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/tiny_register_vm_core.sv =====
// ----------------------------------------------------------------------------
// tiny_register_vm_core: sequenced 16-bit register machine
// Executes one instruction word per input beat, one result beat per input.
// ----------------------------------------------------------------------------
// Each input beat is one instruction (or a restart) and yields exactly one
// result beat with the next fetch address, the output character, the halt
// state and a divide-by-zero flag. The core works on one beat at a time and
// holds in_stall high until the result has gone into the output register.
// All arithmetic runs through one shared 18-bit adder/subtractor. Multiply
// uses 16 shift-add steps, divide two magnitude steps, 16 restoring steps
// and a sign fix, and restart three chained adds for the stack registers.
// A beat also waits in its done state while the previous result sits
// stalled in the output register. Register values live in a small
// two-read-port RAM with per-entry valid bits, so reset and restart clear
// the whole file at once with no clearing pass.
`timescale 1ns / 1ps

module tiny_register_vm_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_program_length,
  // instruction beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_instruction,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_fetch_address,
  output logic [7:0]  out_out_char,
  output logic        out_halted,
  output logic        out_div_by_zero
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EXEC = 4'd1;
  localparam logic [3:0] ST_NEGB = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_DFIX = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_RS0  = 4'd6;
  localparam logic [3:0] ST_RS1  = 4'd7;
  localparam logic [3:0] ST_RS2  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam bit IP_IS_OUT = (tvm_pkg::IP_INDEX == tvm_pkg::OUT_REG);

  logic [3:0]                        state_r, state_nxt;
  logic [tvm_pkg::PROG_LEN_W-1:0]    pl_r;
  logic [tvm_pkg::REG_COUNT-1:0]     valid_r;
  tvm_pkg::word_t                    ip_r;
  tvm_pkg::word_t                    r5_r;
  logic                              halt_r;
  logic                              dz_r;
  logic [15:0]                       ins_r;
  tvm_pkg::word_t                    acc_r;
  tvm_pkg::word_t                    opa_r;
  tvm_pkg::word_t                    opb_r;
  logic [3:0]                        cnt_r;
  logic                              neg_r;

  logic                              out_valid_r;
  tvm_pkg::word_t                    out_addr_r;
  logic [7:0]                        out_char_r;
  logic                              out_halt_r;
  logic                              out_dz_r;

  logic                              in_acc;
  logic                              out_free;

  // register file access
  tvm_pkg::word_t                    rd_a, rd_b;
  tvm_pkg::word_t                    opnd_a, opnd_b;
  logic                              wr_en;
  tvm_pkg::reg_idx_t                 wr_idx;
  tvm_pkg::word_t                    wr_data;
  logic                              ram_we;

  // shared adder
  logic [16:0]                       alu_x, alu_y;
  logic                              alu_sub;
  logic [17:0]                       alu_res;

  tvm_pkg::opcode_t                  op;
  tvm_pkg::reg_idx_t                 ra, rb;
  tvm_pkg::word_t                    imm;
  logic                              div_ge;
  tvm_pkg::word_t                    r5_view;

  assign op  = tvm_pkg::opcode_t'(ins_r[15:12]);
  assign ra  = tvm_pkg::reg_idx_t'(ins_r[11:8]);
  assign rb  = tvm_pkg::reg_idx_t'(ins_r[7:4]);
  assign imm = {{8{ins_r[7]}}, ins_r[7:0]};

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_fetch_address = out_addr_r;
  assign out_out_char      = out_char_r;
  assign out_halted        = out_halt_r;
  assign out_div_by_zero   = out_dz_r;

  assign r5_view = IP_IS_OUT ? ip_r : r5_r;

  tvm_ram #(
    .WIDTH (tvm_pkg::WORD_W),
    .DEPTH (tvm_pkg::REG_COUNT)
  ) u_regs (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr_idx),
    .wdata   (wr_data),
    .raddr_a (tvm_pkg::reg_idx_t'(in_instruction[11:8])),
    .rdata_a (rd_a),
    .raddr_b (tvm_pkg::reg_idx_t'(in_instruction[7:4])),
    .rdata_b (rd_b)
  );

  // operand select: IP and register 5 live in flops, never-written entries read 0
  always_comb begin
    if (ra == tvm_pkg::IP_INDEX) begin
      opnd_a = ip_r;
    end else if (ra == tvm_pkg::OUT_REG) begin
      opnd_a = r5_r;
    end else begin
      opnd_a = valid_r[ra] ? rd_a : '0;
    end
    if (rb == tvm_pkg::IP_INDEX) begin
      opnd_b = ip_r;
    end else if (rb == tvm_pkg::OUT_REG) begin
      opnd_b = r5_r;
    end else begin
      opnd_b = valid_r[rb] ? rd_b : '0;
    end
  end

  assign alu_res = {1'b0, alu_x} + ({1'b0, alu_y} ^ {18{alu_sub}}) + 18'(alu_sub);
  assign div_ge  = !alu_res[17];

  assign ram_we = wr_en && (wr_idx != tvm_pkg::IP_INDEX) && (wr_idx != tvm_pkg::OUT_REG);

  // sequencer: adder operands, write port, next state
  always_comb begin
    alu_x     = '0;
    alu_y     = '0;
    alu_sub   = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = ra;
    wr_data   = alu_res[15:0];
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        // increment IP; register 5 is cleared first when they coincide
        alu_x = {1'b0, (IP_IS_OUT ? '0 : ip_r)};
        alu_y = 17'd1;
        if (in_acc) begin
          if (in_mode) begin
            state_nxt = ST_RS0;
          end else if (halt_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (op)
          tvm_pkg::OP_HALT: begin
          end
          tvm_pkg::OP_LDI: begin
            wr_en   = 1'b1;
            wr_data = imm;
          end
          tvm_pkg::OP_MOV: begin
            wr_en   = 1'b1;
            wr_idx  = rb;
            wr_data = opnd_a;
          end
          tvm_pkg::OP_ADD: begin
            alu_x = {1'b0, opnd_a};
            alu_y = {1'b0, opnd_b};
            wr_en = 1'b1;
          end
          tvm_pkg::OP_SUB: begin
            alu_x   = {1'b0, opnd_a};
            alu_y   = {1'b0, opnd_b};
            alu_sub = 1'b1;
            wr_en   = 1'b1;
          end
          tvm_pkg::OP_MUL: begin
            state_nxt = ST_MUL;
          end
          tvm_pkg::OP_DIV: begin
            // magnitude of the dividend
            alu_y   = {1'b0, opnd_a};
            alu_sub = 1'b1;
            if (opnd_b == '0) begin
              wr_en   = 1'b1;
              wr_data = '0;
            end else begin
              state_nxt = ST_NEGB;
            end
          end
          tvm_pkg::OP_JMP: begin
            alu_x  = {1'b0, ip_r};
            alu_y  = {1'b0, imm};
            wr_en  = 1'b1;
            wr_idx = tvm_pkg::IP_INDEX;
          end
          tvm_pkg::OP_JNZ: begin
            alu_x  = {1'b0, ip_r};
            alu_y  = {1'b0, imm};
            wr_en  = (opnd_a != '0);
            wr_idx = tvm_pkg::IP_INDEX;
          end
          default: begin
          end
        endcase
      end
      ST_NEGB: begin
        alu_y     = {1'b0, opb_r};
        alu_sub   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        alu_x   = {acc_r, opa_r[15]};
        alu_y   = {1'b0, opb_r};
        alu_sub = 1'b1;
        if (cnt_r == '1) begin
          state_nxt = ST_DFIX;
        end
      end
      ST_DFIX: begin
        alu_y     = {1'b0, opa_r};
        alu_sub   = 1'b1;
        wr_en     = 1'b1;
        wr_data   = neg_r ? alu_res[15:0] : opa_r;
        state_nxt = ST_DONE;
      end
      ST_MUL: begin
        alu_x = {1'b0, acc_r};
        alu_y = opb_r[0] ? {1'b0, opa_r} : '0;
        if (cnt_r == '1) begin
          wr_en     = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_RS0: begin
        alu_x     = 17'(pl_r);
        alu_y     = {1'b0, tvm_pkg::STACK_GAP};
        wr_en     = 1'b1;
        wr_idx    = tvm_pkg::SS_INDEX;
        state_nxt = ST_RS1;
      end
      ST_RS1: begin
        alu_x     = {1'b0, acc_r};
        alu_y     = 17'(tvm_pkg::STACK_WORDS);
        wr_en     = 1'b1;
        wr_idx    = tvm_pkg::SP_INDEX;
        state_nxt = ST_RS2;
      end
      ST_RS2: begin
        alu_x     = {1'b0, acc_r};
        alu_y     = {1'b0, tvm_pkg::STACK_GAP};
        wr_en     = 1'b1;
        wr_idx    = tvm_pkg::SU_INDEX;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pl_r        <= '0;
      valid_r     <= '0;
      ip_r        <= '0;
      r5_r        <= '0;
      halt_r      <= 1'b0;
      dz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        pl_r <= cfg_program_length;
      end

      // load a new result beat, or drop the one just taken
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            ins_r <= in_instruction;
            dz_r  <= 1'b0;
            if (in_mode) begin
              valid_r <= '0;
              ip_r    <= '0;
              r5_r    <= '0;
              halt_r  <= 1'b0;
            end else if (!halt_r) begin
              r5_r <= '0;
              ip_r <= alu_res[15:0];
            end
          end
        end
        ST_EXEC: begin
          acc_r <= '0;
          cnt_r <= '0;
          opa_r <= ((op == tvm_pkg::OP_DIV) && opnd_a[15]) ? alu_res[15:0] : opnd_a;
          opb_r <= opnd_b;
          neg_r <= opnd_a[15] ^ opnd_b[15];
          if (op == tvm_pkg::OP_HALT) begin
            halt_r <= 1'b1;
          end
          if ((op == tvm_pkg::OP_DIV) && (opnd_b == '0)) begin
            dz_r <= 1'b1;
          end
        end
        ST_NEGB: begin
          opb_r <= opb_r[15] ? alu_res[15:0] : opb_r;
        end
        ST_DIV: begin
          acc_r <= div_ge ? alu_res[15:0] : {acc_r[14:0], opa_r[15]};
          opa_r <= {opa_r[14:0], div_ge};
          cnt_r <= cnt_r + 4'd1;
        end
        ST_MUL: begin
          acc_r <= alu_res[15:0];
          opa_r <= {opa_r[14:0], 1'b0};
          opb_r <= {1'b0, opb_r[15:1]};
          cnt_r <= cnt_r + 4'd1;
        end
        ST_RS0, ST_RS1: begin
          acc_r <= alu_res[15:0];
        end
        ST_DONE: begin
          if (out_free) begin
            out_addr_r  <= ip_r;
            out_char_r  <= r5_view[7:0];
            out_halt_r  <= halt_r;
            out_dz_r    <= dz_r;
          end
        end
        default: begin
        end
      endcase

      // register file write-back; IP wins over register 5 when they coincide
      if (wr_en) begin
        if (wr_idx == tvm_pkg::IP_INDEX) begin
          ip_r <= wr_data;
        end else if (wr_idx == tvm_pkg::OUT_REG) begin
          r5_r <= wr_data;
        end else begin
          valid_r[wr_idx] <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  // an accepted beat always starts work
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted beat did not leave idle");

  // divider iterations never run with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (opb_r != '0))
    else $error("divide iteration with zero divisor");

  // iteration count starts at zero on entry to the divide loop
  a_div_cnt_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && ($past(state_r) == ST_NEGB)) |-> (cnt_r == '0))
    else $error("divide loop entered with stale count");

  // the halt flag drops only through a restart beat
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(halt_r)) |-> $past(in_acc && in_mode))
    else $error("halt flag cleared without restart");

  // a result is loaded only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside done state");
`endif

endmodule
